// ===== src/cmdr_pkg.sv =====
// cmdr_pkg: shared types, limits and keyword tables for the command line router
// depends on nothing; imported by command_line_router
package cmdr_pkg;

  localparam int NUM_BOARDS      = 12;
  localparam int NUM_CONTROLLERS = 6;
  localparam int LEN_W           = 16;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // verdict codes
  typedef enum logic [2:0] {
    RK_LOCAL   = 3'd0,
    RK_BOARD   = 3'd1,
    RK_CTRL    = 3'd2,
    RK_BCAST   = 3'd3,
    RK_INVALID = 3'd4
  } route_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_BOARD = 2'd1,
    ERR_CTRL  = 2'd2
  } err_code_e;

  typedef enum logic [1:0] {
    TAG_BOTH   = 2'd0,
    TAG_FIRST  = 2'd1,
    TAG_SECOND = 2'd2
  } board_tag_e;

  // result word, lowest field last so it lands in the low bits
  typedef struct packed {
    logic             pad;
    err_code_e        error_code;
    logic [LEN_W-1:0] payload_length;
    logic [LEN_W-1:0] payload_start;
    logic             urgent;
    board_tag_e       board_tag;
    logic [2:0]       target_controller;
    logic [3:0]       target_board;
    route_kind_e      route_kind;
  } result_t;

  // urgent keywords
  localparam int NUM_URG = 3;
  localparam logic [1:0] URG_STOP    = 2'd0;
  localparam logic [1:0] URG_CANCEL  = 2'd1;
  localparam logic [1:0] URG_STOPALL = 2'd2;

  function automatic logic [3:0] urg_len(input logic [1:0] cand);
    logic [3:0] len;
    case (cand)
      URG_STOP:    len = 4'd4;
      URG_CANCEL:  len = 4'd6;
      URG_STOPALL: len = 4'd11;
      default:     len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] urg_char(input logic [1:0] cand, input logic [3:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (cand)
      URG_STOP: begin
        case (idx)
          4'd0:    ch = "s";
          4'd1:    ch = "t";
          4'd2:    ch = "o";
          4'd3:    ch = "p";
          default: ch = 8'h00;
        endcase
      end
      URG_CANCEL: begin
        case (idx)
          4'd0:    ch = "c";
          4'd1:    ch = "a";
          4'd2:    ch = "n";
          4'd3:    ch = "c";
          4'd4:    ch = "e";
          4'd5:    ch = "l";
          default: ch = 8'h00;
        endcase
      end
      URG_STOPALL: begin
        case (idx)
          4'd0:    ch = "@";
          4'd1:    ch = "0";
          4'd2:    ch = " ";
          4'd3:    ch = "s";
          4'd4:    ch = "t";
          4'd5:    ch = "o";
          4'd6:    ch = "p";
          4'd7:    ch = "_";
          4'd8:    ch = "a";
          4'd9:    ch = "l";
          4'd10:   ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/command_line_router.sv =====
// command_line_router: parses a command line word by word and issues one routing verdict
// depends on cmdr_pkg
// the verdict is valid on m_axis in the cycle after the end-of-line word is taken
// throughput: one input word per cycle; byte words are taken even while a verdict waits,
//   an end-of-line word waits only while the previous verdict is still held downstream
// the line parser and keyword matcher update in the same cycle a word is taken
// reset (rst_ni low, asynchronous): parser back at line start, no verdict pending
module command_line_router
  import cmdr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  logic        s_axis_tuser_i,   // [0] kind (1 = end of line)
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // [2:0] route_kind, [6:3] target_board,
                                        // [9:7] target_controller, [11:10] board_tag,
                                        // [12] urgent, [28:13] payload_start,
                                        // [44:29] payload_length, [46:45] error_code
);

  // parser phases
  typedef enum logic [3:0] {
    PH_START, PH_M, PH_MC, PH_LOCAL, PH_BCAST, PH_INVALID,
    PH_ADDR_FIRST, PH_AT_ZERO, PH_DIGITS, PH_SPACE_SEEN, PH_PAYLOAD
  } phase_e;

  // which marker opened the address
  typedef enum logic [1:0] {
    RC_BOARD, RC_CTRL, RC_BCAST
  } rclass_e;

  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_M    = 8'h6d;
  localparam logic [7:0] CH_C    = 8'h63;
  localparam logic [7:0] CH_US   = 8'h5f;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_9    = 8'h39;

  localparam logic [1:0] MAX_DIGITS = 2'd3;

  // parser state
  phase_e           phase_q, phase_d;
  rclass_e          rclass_q, rclass_d;
  logic [LEN_W-1:0] line_pos_q, line_pos_d;
  logic [LEN_W-1:0] pay_off_q, pay_off_d;
  logic [9:0]       addr_q, addr_d;
  logic [1:0]       digits_q, digits_d;

  // keyword matcher state
  logic             urg_on_q, urg_on_d;     // past the leading blanks
  logic [3:0]       urg_idx_q, urg_idx_d;
  logic [2:0]       urg_cand_q, urg_cand_d;

  // result register
  logic             m_valid_q, m_valid_d;
  result_t          res_q, res_d;

  logic        take, take_byte, take_end;
  logic [7:0]  b;
  logic        is_digit, is_blank, space_hit, advanced, urg_hit;
  logic [12:0] addr_mac;
  logic [10:0] addr_inc;
  logic [3:0]  cand_len;

  assign s_axis_tready_o = m_axis_tready_i | ~m_valid_q | ~s_axis_tuser_i;
  assign take      = s_axis_tvalid_i & s_axis_tready_o;
  assign take_byte = take & ~s_axis_tuser_i;
  assign take_end  = take & s_axis_tuser_i;

  assign b        = s_axis_tdata_i;
  assign is_digit = (b >= CH_0) && (b <= CH_9);
  assign is_blank = (b == CH_SP) || (b == CH_TAB);
  // address accumulate: addr * 10 + digit
  assign addr_mac = {addr_q, 3'b000} + {2'b00, addr_q, 1'b0} + {9'd0, b[3:0]};
  assign addr_inc = {1'b0, addr_q} + 11'd1;

  // space after the address digits opens the payload and restarts keyword matching
  assign space_hit = (phase_q == PH_DIGITS) && !(is_digit && digits_q < MAX_DIGITS) &&
                     (b == CH_SP);

  // keyword verdict from the current matcher state
  always_comb begin
    urg_hit = 1'b0;
    for (int c = 0; c < NUM_URG; c++) begin
      if (urg_cand_q[c] && urg_idx_q == urg_len(2'(c))) urg_hit = 1'b1;
    end
    urg_hit = urg_hit & urg_on_q;
  end

  always_comb begin
    phase_d    = phase_q;
    rclass_d   = rclass_q;
    line_pos_d = line_pos_q;
    pay_off_d  = pay_off_q;
    addr_d     = addr_q;
    digits_d   = digits_q;
    urg_on_d   = urg_on_q;
    urg_idx_d  = urg_idx_q;
    urg_cand_d = urg_cand_q;
    advanced   = 1'b0;
    cand_len   = 4'd0;
    res_d      = res_q;
    m_valid_d  = m_valid_q & ~m_axis_tready_i;

    if (take_byte) begin
      // line parser
      case (phase_q)
        PH_START: begin
          if (b == CH_AT) begin
            phase_d  = PH_ADDR_FIRST;
            rclass_d = RC_BOARD;
          end else if (b == CH_HASH) begin
            phase_d  = PH_ADDR_FIRST;
            rclass_d = RC_CTRL;
          end else if (b == CH_M) begin
            phase_d = PH_M;
          end else begin
            phase_d = PH_BCAST;
          end
        end
        PH_M:  phase_d = (b == CH_C) ? PH_MC : PH_BCAST;
        PH_MC: phase_d = (b == CH_US) ? PH_LOCAL : PH_BCAST;
        PH_ADDR_FIRST: begin
          if (b >= CH_1 && b <= CH_9) begin
            addr_d   = {6'd0, b[3:0]};
            digits_d = 2'd1;
            phase_d  = PH_DIGITS;
          end else if (b == CH_0 && rclass_q == RC_BOARD) begin
            phase_d = PH_AT_ZERO;
          end else begin
            phase_d = PH_INVALID;
          end
        end
        PH_AT_ZERO: begin
          if (b == CH_SP) begin
            phase_d  = PH_BCAST;
            rclass_d = RC_BCAST;
          end else begin
            phase_d = PH_INVALID;
          end
        end
        PH_DIGITS: begin
          if (is_digit && digits_q < MAX_DIGITS) begin
            addr_d   = addr_mac[9:0];
            digits_d = digits_q + 2'd1;
          end else if (b == CH_SP) begin
            pay_off_d = line_pos_q + LEN_W'(1);
            phase_d   = PH_SPACE_SEEN;
          end else begin
            phase_d = PH_INVALID;
          end
        end
        PH_SPACE_SEEN: phase_d = PH_PAYLOAD;
        default: ;
      endcase

      // keyword matcher, all candidates share one index
      if (space_hit) begin
        urg_on_d   = 1'b0;
        urg_idx_d  = '0;
        urg_cand_d = '1;
      end else if (urg_on_q || !is_blank) begin
        urg_on_d = 1'b1;
        for (int c = 0; c < NUM_URG; c++) begin
          cand_len = urg_len(2'(c));
          if (urg_cand_q[c]) begin
            if (urg_idx_q < cand_len && urg_char(2'(c), urg_idx_q) == b) begin
              advanced = 1'b1;
            end else if (!(urg_idx_q == cand_len && is_blank)) begin
              urg_cand_d[c] = 1'b0;
            end
          end
        end
        if (advanced && urg_idx_q != 4'hf) urg_idx_d = urg_idx_q + 4'd1;
      end

      if (line_pos_q != LEN_MAX) line_pos_d = line_pos_q + LEN_W'(1);
    end

    if (take_end) begin
      res_d = '0;
      res_d.route_kind = RK_INVALID;
      res_d.error_code = (rclass_q == RC_CTRL) ? ERR_CTRL : ERR_BOARD;
      case (phase_q)
        PH_LOCAL: begin
          res_d.route_kind = RK_LOCAL;
          res_d.error_code = ERR_NONE;
        end
        PH_START, PH_M, PH_MC, PH_BCAST: begin
          res_d.route_kind = RK_BCAST;
          res_d.error_code = ERR_NONE;
          res_d.urgent     = urg_hit;
        end
        PH_PAYLOAD: begin
          if (rclass_q == RC_BOARD && addr_q != '0 && addr_q <= 10'(NUM_BOARDS)) begin
            res_d.route_kind        = RK_BOARD;
            res_d.error_code        = ERR_NONE;
            res_d.target_board      = addr_q[3:0];
            res_d.target_controller = addr_inc[3:1];
            res_d.board_tag         = addr_q[0] ? TAG_FIRST : TAG_SECOND;
            res_d.urgent            = urg_hit;
            res_d.payload_start     = pay_off_q;
          end else if (rclass_q == RC_CTRL && addr_q != '0 &&
                       addr_q <= 10'(NUM_CONTROLLERS)) begin
            res_d.route_kind        = RK_CTRL;
            res_d.error_code        = ERR_NONE;
            res_d.target_controller = addr_q[2:0];
            res_d.urgent            = urg_hit;
            res_d.payload_start     = pay_off_q;
          end
        end
        default: ;
      endcase
      // a saturated count reports the maximum
      res_d.payload_length = (line_pos_q == LEN_MAX) ? LEN_MAX :
                             line_pos_q - res_d.payload_start;
      m_valid_d = 1'b1;

      // back to line start
      phase_d    = PH_START;
      rclass_d   = RC_BCAST;
      line_pos_d = '0;
      pay_off_d  = '0;
      addr_d     = '0;
      digits_d   = '0;
      urg_on_d   = 1'b0;
      urg_idx_d  = '0;
      urg_cand_d = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      rclass_q   <= RC_BCAST;
      line_pos_q <= '0;
      pay_off_q  <= '0;
      addr_q     <= '0;
      digits_q   <= '0;
      urg_on_q   <= 1'b0;
      urg_idx_q  <= '0;
      urg_cand_q <= '1;
      m_valid_q  <= 1'b0;
      res_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      rclass_q   <= rclass_d;
      line_pos_q <= line_pos_d;
      pay_off_q  <= pay_off_d;
      addr_q     <= addr_d;
      digits_q   <= digits_d;
      urg_on_q   <= urg_on_d;
      urg_idx_q  <= urg_idx_d;
      urg_cand_q <= urg_cand_d;
      m_valid_q  <= m_valid_d;
      res_q      <= res_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = res_q;

  // an end-of-line word always leaves a verdict pending
  a_end_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_end |=> m_valid_q)
    else $error("no verdict after end of line");

  // an end-of-line word restarts the byte count
  a_end_clears_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_end |=> (line_pos_q == '0 && phase_q == PH_START))
    else $error("parser not back at line start");

  // error code set exactly for invalid verdicts
  a_err_iff_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> ((res_q.error_code != ERR_NONE) == (res_q.route_kind == RK_INVALID)))
    else $error("error code and route kind disagree");

  // board fields only on board routes
  a_board_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_q.route_kind != RK_BOARD) |->
      (res_q.target_board == '0 && res_q.board_tag == TAG_BOTH))
    else $error("board fields set on a non-board route");

endmodule
